@@ design/page_replacement_engine_unit_defines.svh @@
`ifndef PAGE_REPLACEMENT_ENGINE_UNIT_DEFINES_SVH
`define PAGE_REPLACEMENT_ENGINE_UNIT_DEFINES_SVH

// check a property on every rising edge of clk outside reset
`define PRE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition never holds outside reset
`define PRE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ design/pre_pkg.sv @@
package pre_pkg;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF  = 8;

	localparam int USE_W   = 16;
	localparam int TIME_W  = 32;
	localparam int CNT_W   = 32;
	localparam int POL_W   = 2;
	localparam int FIU_W   = 5;
	localparam int SLOT_W  = 4;
	localparam int EPG_W   = 8;
	localparam int PGIN_W  = 8;
	localparam int CFG_W   = 5;
	localparam int CIDX_W  = 1;

	localparam logic [POL_W-1:0] POL_LFU   = 2'd1;
	localparam logic [POL_W-1:0] POL_CLOCK = 2'd2;

	localparam logic [CIDX_W-1:0] REG_POLICY = 1'd0;
	localparam logic [CIDX_W-1:0] REG_FRAMES = 1'd1;

	localparam logic [FIU_W-1:0] FRAMES_RESET = 5'd16;

	typedef enum logic [3:0] {
		ST_INIT_CLR,
		ST_IDLE,
		ST_CLR,
		ST_HIST_RD,
		ST_HIST_WB,
		ST_SCAN,
		ST_DECIDE,
		ST_CLOCK,
		ST_FRM_RD,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic clr_en;
		logic hist_wb;
		logic scan_step;
		logic decide;
		logic clock_step;
		logic commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic req;
		logic restart;
		logic clr_last;
		logic scan_done;
		logic need_clock;
		logic clock_found;
		logic out_free;
	} status_t;

endpackage

@@ design/pre_ram.sv @@
module pre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/pre_ctrl.sv @@
`include "page_replacement_engine_unit_defines.svh"

module pre_ctrl import pre_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output cmd_t    cmd,
	output logic    in_ready
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_INIT_CLR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (status.req) begin
					cmd.accept = 1'b1;
					state_d = status.restart ? ST_CLR : ST_HIST_RD;
				end
			end
			ST_CLR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) state_d = ST_HIST_RD;
			end
			ST_HIST_RD: state_d = ST_HIST_WB;
			ST_HIST_WB: begin
				cmd.hist_wb = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = status.need_clock ? ST_CLOCK : ST_FRM_RD;
			end
			ST_CLOCK: begin
				cmd.clock_step = 1'b1;
				if (status.clock_found) state_d = ST_FRM_RD;
			end
			ST_FRM_RD: state_d = ST_WRITE;
			ST_WRITE: begin
				cmd.commit = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`PRE_ASSERT(a_accept_next, cmd.accept |=> (state_q == ST_CLR || state_q == ST_HIST_RD), "accept did not start work")
	`PRE_NEVER(a_load_blocked, cmd.load_out && !status.out_free, "result loaded over a waiting word")

endmodule

@@ design/pre_dp.sv @@
`include "page_replacement_engine_unit_defines.svh"

module pre_dp import pre_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic              cfg_write,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic [PGIN_W-1:0] page_number,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic [SLOT_W-1:0] frame_slot,
	output logic              evicted_valid,
	output logic [EPG_W-1:0]  evicted_page,
	output logic [CNT_W-1:0]  replacement_count
);

	localparam int FIDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int FCNT_W = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W  = (FCNT_W > FIU_W) ? FCNT_W : FIU_W;
	localparam int FW     = PAGE_BITS + USE_W + TIME_W;
	localparam int HDEPTH = 1 << PAGE_BITS;
	localparam logic [CMP_W-1:0] MAXC = CMP_W'(MAX_FRAMES);

	function automatic logic [FIDX_W-1:0] wrap_inc(input logic [FIDX_W-1:0] p,
		input logic [FCNT_W-1:0] lim);
		logic [FCNT_W-1:0] s;
		s = FCNT_W'(p) + FCNT_W'(1);
		return (s == lim) ? '0 : FIDX_W'(s);
	endfunction

	logic [POL_W-1:0]     policy_q;
	logic [FIU_W-1:0]     fiu_q;
	logic [FCNT_W-1:0]    n;
	logic [PAGE_BITS-1:0] page_q;
	logic [PAGE_BITS-1:0] clr_addr_q;
	logic [USE_W-1:0]     hist_rd, hist_new, hist_q;
	logic [FW-1:0]        frm_rd, frm_wd;
	logic [FIDX_W-1:0]    frm_raddr;
	logic [PAGE_BITS-1:0] e_page;
	logic [USE_W-1:0]     e_use;
	logic [TIME_W-1:0]    e_time;

	logic [MAX_FRAMES-1:0] valid_q, ref_q;
	logic [FCNT_W-1:0]     filled_q, scan_addr_q;
	logic [FIDX_W-1:0]     vp_q, vp_eff, slot_q, hit_idx_q, best_idx_q, idx_s1;
	logic                  vld_s1, hit_q, full;
	logic [USE_W-1:0]      best_use_q;
	logic [TIME_W-1:0]     best_time_q, insert_q;
	logic [CNT_W-1:0]      repl_q;

	logic                 res_hit_q, res_ev_q;
	logic [FIDX_W-1:0]    res_slot_q;
	logic [PAGE_BITS-1:0] res_page_q;
	logic                 ev;

	always_comb begin
		if (fiu_q == '0) begin
			n = FCNT_W'(1);
		end else if (CMP_W'(fiu_q) > MAXC) begin
			n = FCNT_W'(MAX_FRAMES);
		end else begin
			n = FCNT_W'(fiu_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
			fiu_q    <= FRAMES_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_POLICY: policy_q <= POL_W'(cfg_data);
				REG_FRAMES: fiu_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign hist_new = (hist_rd == '1) ? hist_rd : hist_rd + USE_W'(1);

	pre_ram #(.WIDTH(USE_W), .DEPTH(HDEPTH)) u_hist (
		.clk   (clk),
		.we    (cmd.clr_en | cmd.hist_wb),
		.waddr (cmd.clr_en ? clr_addr_q : page_q),
		.wdata (cmd.clr_en ? '0 : hist_new),
		.raddr (page_q),
		.rdata (hist_rd)
	);

	assign frm_raddr = cmd.scan_step ? FIDX_W'(scan_addr_q) : slot_q;
	assign e_page    = frm_rd[FW-1 -: PAGE_BITS];
	assign e_use     = frm_rd[TIME_W +: USE_W];
	assign e_time    = frm_rd[TIME_W-1:0];
	assign frm_wd    = {page_q, hist_q, hit_q ? e_time : insert_q};

	pre_ram #(.WIDTH(FW), .DEPTH(MAX_FRAMES)) u_frames (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (slot_q),
		.wdata (frm_wd),
		.raddr (frm_raddr),
		.rdata (frm_rd)
	);

	assign full   = !(filled_q < n);
	assign vp_eff = (FCNT_W'(vp_q) >= n) ? '0 : vp_q;
	assign ev     = !hit_q && valid_q[slot_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			valid_q     <= '0;
			ref_q       <= '0;
			filled_q    <= '0;
			vp_q        <= '0;
			insert_q    <= '0;
			repl_q      <= '0;
			scan_addr_q <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			if (cmd.clr_en) clr_addr_q <= clr_addr_q + PAGE_BITS'(1);
			if (cmd.accept && restart) begin
				valid_q  <= '0;
				ref_q    <= '0;
				filled_q <= '0;
				vp_q     <= '0;
				insert_q <= '0;
				repl_q   <= '0;
			end
			if (cmd.hist_wb) begin
				scan_addr_q <= '0;
				vld_s1      <= 1'b0;
				hit_q       <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (scan_addr_q < n) begin
					scan_addr_q <= scan_addr_q + FCNT_W'(1);
					vld_s1      <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
				if (vld_s1 && !hit_q && valid_q[idx_s1] && e_page == page_q) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.decide && !hit_q) begin
				if (!full) begin
					filled_q <= filled_q + FCNT_W'(1);
				end else if (policy_q == POL_LFU || policy_q == POL_CLOCK) begin
					vp_q <= vp_eff;
				end else begin
					vp_q <= wrap_inc(vp_eff, n);
				end
			end
			if (cmd.clock_step) begin
				vp_q <= wrap_inc(vp_q, n);
				if (ref_q[vp_q]) ref_q[vp_q] <= 1'b0;
			end
			if (cmd.commit) begin
				valid_q[slot_q] <= 1'b1;
				ref_q[slot_q]   <= hit_q;
				if (!hit_q && insert_q != '1) insert_q <= insert_q + TIME_W'(1);
				if (ev && repl_q != '1) repl_q <= repl_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) page_q <= PAGE_BITS'(page_number);
		if (cmd.hist_wb) hist_q <= hist_new;
		if (cmd.scan_step) idx_s1 <= FIDX_W'(scan_addr_q);
		if (cmd.scan_step && vld_s1) begin
			if (!hit_q && valid_q[idx_s1] && e_page == page_q) hit_idx_q <= idx_s1;
			if (idx_s1 == '0 || e_use < best_use_q ||
				(e_use == best_use_q && e_time < best_time_q)) begin
				best_idx_q  <= idx_s1;
				best_use_q  <= e_use;
				best_time_q <= e_time;
			end
		end
		if (cmd.decide) begin
			if (hit_q) begin
				slot_q <= hit_idx_q;
			end else if (!full) begin
				slot_q <= FIDX_W'(filled_q);
			end else if (policy_q == POL_LFU) begin
				slot_q <= best_idx_q;
			end else begin
				slot_q <= vp_eff;
			end
		end
		if (cmd.clock_step && !ref_q[vp_q]) slot_q <= vp_q;
		if (cmd.commit) begin
			res_hit_q  <= hit_q;
			res_slot_q <= slot_q;
			res_ev_q   <= ev;
			res_page_q <= ev ? e_page : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit               <= res_hit_q;
			frame_slot        <= SLOT_W'(res_slot_q);
			evicted_valid     <= res_ev_q;
			evicted_page      <= EPG_W'(res_page_q);
			replacement_count <= repl_q;
		end
	end

	assign status.req         = in_valid;
	assign status.restart     = restart;
	assign status.clr_last    = &clr_addr_q;
	assign status.scan_done   = (scan_addr_q == n) && !vld_s1;
	assign status.need_clock  = !hit_q && full && policy_q == POL_CLOCK;
	assign status.clock_found = !ref_q[vp_q];
	assign status.out_free    = !out_valid || out_ready;

	`PRE_ASSERT(a_slot_in_range, cmd.commit |-> (FCNT_W'(slot_q) < n), "slot beyond active frames")
	`PRE_ASSERT(a_hit_resident, (cmd.commit && hit_q) |-> valid_q[slot_q], "hit on an empty frame")
	`PRE_ASSERT(a_sweep_in_range, cmd.clock_step |-> (FCNT_W'(vp_q) < n), "clock hand beyond active frames")

endmodule

@@ design/page_replacement_engine_unit.sv @@
// Page replacement engine: one page reference per input word, one result word per reference.
// After reset, and for every reference with restart set, the per-page history store
// is cleared one entry a cycle, all 2**PAGE_BITS entries, with no word accepted meanwhile.
// A reference then runs the frame table scan over the n active frames, n being the active
// frame count, held to 1..MAX_FRAMES (one frame a cycle through the frame memory's read
// port, which finds a hit and the least used frame together); under the second chance
// policy a miss on a full table adds the clock sweep, one frame a cycle. One reference is
// in flight at a time; a result waits in the output register while the next reference is
// taken.
module page_replacement_engine_unit import pre_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PGIN_W-1:0] page_number,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              hit,
	output logic [SLOT_W-1:0] frame_slot,
	output logic              evicted_valid,
	output logic [EPG_W-1:0]  evicted_page,
	output logic [CNT_W-1:0]  replacement_count
);

	cmd_t    cmd;
	status_t status;

	pre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	pre_dp #(.MAX_FRAMES(MAX_FRAMES), .PAGE_BITS(PAGE_BITS)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.page_number       (page_number),
		.restart           (restart),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.hit               (hit),
		.frame_slot        (frame_slot),
		.evicted_valid     (evicted_valid),
		.evicted_page      (evicted_page),
		.replacement_count (replacement_count)
	);

endmodule
